@@ hdl/dtrq_pkg.sv @@
// Package for the dependency tracking request queue.
// Holds operation codes, error codes, field widths and the cell command type. No dependencies.
package dtrq_pkg;

  localparam logic [2:0] KIND_FIND   = 3'd0;
  localparam logic [2:0] KIND_ENQ    = 3'd1;
  localparam logic [2:0] KIND_WAKE   = 3'd2;
  localparam logic [2:0] KIND_POP    = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_EMPTY   = 2'd2;
  localparam logic [1:0] ERR_WAITING = 2'd3;

  localparam int LEN_BITS  = 9;
  localparam int ROW_BITS  = 16;
  localparam int TIME_BITS = 48;

  // Command broadcast from the control into every cell.
  typedef struct packed {
    logic wake;    // wakeup by id
    logic shift;   // pop: every cell takes its neighbor's entry
    logic load;    // enqueue at the tail position
  } cell_cmd_t;

endpackage

@@ hdl/dtrq_cell.sv @@
// One queue slot: entry storage plus per-entry comparators.
// Depends on dtrq_pkg. Entries shift toward slot 0 (the front) on pop.
module dtrq_cell #(
  parameter int ID_BITS   = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                          clk,
  input  dtrq_pkg::cell_cmd_t           cmd,
  input  logic                          is_tail,     // load target on enqueue
  // new entry
  input  logic [ID_BITS-1:0]            new_id,
  input  logic [ADDR_BITS-1:0]          new_addr,
  input  logic [dtrq_pkg::LEN_BITS-1:0] new_len,
  input  logic [dtrq_pkg::ROW_BITS-1:0] new_row,
  input  logic                          new_write,
  input  logic                          new_waiting,
  input  logic [ID_BITS-1:0]            new_wait_id,
  input  logic [dtrq_pkg::TIME_BITS-1:0] new_time,
  // neighbor entry (slot above)
  input  logic [ID_BITS-1:0]            nb_id,
  input  logic [ADDR_BITS-1:0]          nb_addr,
  input  logic [dtrq_pkg::LEN_BITS-1:0] nb_len,
  input  logic [dtrq_pkg::ROW_BITS-1:0] nb_row,
  input  logic                          nb_write,
  input  logic                          nb_waiting,
  input  logic [ID_BITS-1:0]            nb_wait_id,
  input  logic [dtrq_pkg::TIME_BITS-1:0] nb_time,
  // query
  input  logic [ADDR_BITS-1:0]          q_addr,
  input  logic [dtrq_pkg::LEN_BITS-1:0] q_len,
  input  logic [ID_BITS-1:0]            q_wake_id,
  input  logic [dtrq_pkg::ROW_BITS-1:0] q_row,
  input  logic                          q_write,
  // stored entry
  output logic [ID_BITS-1:0]            id,
  output logic [ADDR_BITS-1:0]          addr,
  output logic [dtrq_pkg::LEN_BITS-1:0] len,
  output logic [dtrq_pkg::ROW_BITS-1:0] row,
  output logic                          write,
  output logic                          waiting,
  output logic [ID_BITS-1:0]            wait_id,
  output logic [dtrq_pkg::TIME_BITS-1:0] time_stamp,
  // comparator results
  output logic                          overlap,
  output logic                          row_hit
);

  logic [ADDR_BITS:0] q_end, e_end;
  logic               wake_hit;

  assign q_end    = {1'b0, q_addr} + (ADDR_BITS+1)'(q_len);
  assign e_end    = {1'b0, addr} + (ADDR_BITS+1)'(len);
  assign overlap  = (q_len != '0) && (len != '0) &&
                    ({1'b0, q_addr} < e_end) && ({1'b0, addr} < q_end);
  assign row_hit  = (row == q_row) && (write == q_write);
  assign wake_hit = waiting && (wait_id == q_wake_id);

  always_ff @(posedge clk) begin
    if (cmd.load && is_tail) begin
      id <= new_id; addr <= new_addr; len <= new_len; row <= new_row;
      write <= new_write; waiting <= new_waiting; wait_id <= new_wait_id;
      time_stamp <= new_time;
    end else if (cmd.shift) begin
      id <= nb_id; addr <= nb_addr; len <= nb_len; row <= nb_row;
      write <= nb_write; waiting <= nb_waiting; wait_id <= nb_wait_id;
      time_stamp <= nb_time;
    end else if (cmd.wake && wake_hit) begin
      waiting <= 1'b0;
      wait_id <= '0;
    end
  end

endmodule

@@ hdl/dependency_tracking_request_queue_unit.sv @@
// Steps: once an item is accepted, the cell chain's comparators are scanned and the chain
//   is updated, then the output register is loaded and out_valid rises.
// Flow: a new item is not accepted before the last one's output register is loaded;
//   in_stall stays high until then, and also while a waiting result is stalled.
// Reset: rst (synchronous) empties the queue and clears the output valid;
//   entry storage is not cleared, empty slots are never read.
module dependency_tracking_request_queue_unit #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  logic [ID_BITS-1:0]    txn_id,
  input  logic [ADDR_BITS-1:0]  start_address,
  input  logic [8:0]            byte_count,
  input  logic [15:0]           dram_row,
  input  logic                  is_write,
  input  logic                  dep_valid,
  input  logic [ID_BITS-1:0]    dep_id,
  input  logic [47:0]           arrival_time,
  input  logic                  count_writes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            error_code,
  output logic                  match_found,
  output logic [ID_BITS-1:0]    match_id,
  output logic [$clog2(DEPTH+1)-1:0] run_count,
  output logic                  front_ready,
  output logic [ID_BITS-1:0]    front_id,
  output logic                  front_dep_valid,
  output logic [ID_BITS-1:0]    front_dep_id,
  output logic [47:0]           front_time,
  output logic [$clog2(DEPTH+1)-1:0] occupancy
);

  localparam int CNT_BITS = $clog2(DEPTH+1);

  // Captured request; busy while it is being worked on.
  logic                 busy;
  logic                 phase2;
  logic                 act;      // single update cycle of the captured request
  logic [2:0]           r_kind;
  logic [ID_BITS-1:0]   r_id, r_dep;
  logic [ADDR_BITS-1:0] r_addr;
  logic [8:0]           r_len;
  logic [15:0]          r_row;
  logic                 r_write, r_dvalid, r_cw;
  logic [47:0]          r_time;
  logic [CNT_BITS-1:0]  held;

  // Cell chain storage, index 0 is the front.
  logic [ID_BITS-1:0]   c_id      [DEPTH];
  logic [ADDR_BITS-1:0] c_addr    [DEPTH];
  logic [8:0]           c_len     [DEPTH];
  logic [15:0]          c_row     [DEPTH];
  logic                 c_write   [DEPTH];
  logic                 c_waiting [DEPTH];
  logic [ID_BITS-1:0]   c_wait_id [DEPTH];
  logic [47:0]          c_time    [DEPTH];
  logic [DEPTH-1:0]     c_overlap, c_row_hit;

  dtrq_pkg::cell_cmd_t  cmd;
  logic [1:0]           err;
  logic                 full, empty;

  assign full  = (held == CNT_BITS'(DEPTH));
  assign empty = (held == '0);
  assign act   = busy && !phase2;

  always_comb begin
    cmd = '0;
    err = dtrq_pkg::ERR_OK;
    unique case (r_kind)
      dtrq_pkg::KIND_ENQ: begin
        if (full) err = dtrq_pkg::ERR_FULL;
        else      cmd.load = act;
      end
      dtrq_pkg::KIND_WAKE: cmd.wake = act;
      dtrq_pkg::KIND_POP: begin
        if (empty)             err = dtrq_pkg::ERR_EMPTY;
        else if (c_waiting[0]) err = dtrq_pkg::ERR_WAITING;
        else                   cmd.shift = act;
      end
      default: ;
    endcase
  end

  // Row compared by count is the front's row.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int NB = (g == DEPTH-1) ? g : g + 1;
    dtrq_cell #(.ID_BITS(ID_BITS), .ADDR_BITS(ADDR_BITS)) u_cell (
      .clk, .cmd,
      .is_tail   (held[CNT_BITS-1:0] == CNT_BITS'(g)),
      .new_id (r_id), .new_addr (r_addr), .new_len (r_len), .new_row (r_row),
      .new_write (r_write), .new_waiting (r_dvalid),
      .new_wait_id (r_dvalid ? r_dep : '0), .new_time (r_time),
      .nb_id (c_id[NB]), .nb_addr (c_addr[NB]), .nb_len (c_len[NB]),
      .nb_row (c_row[NB]), .nb_write (c_write[NB]), .nb_waiting (c_waiting[NB]),
      .nb_wait_id (c_wait_id[NB]), .nb_time (c_time[NB]),
      .q_addr (r_addr), .q_len (r_len), .q_wake_id (r_dep),
      .q_row (c_row[0]), .q_write (r_cw),
      .id (c_id[g]), .addr (c_addr[g]), .len (c_len[g]), .row (c_row[g]),
      .write (c_write[g]), .waiting (c_waiting[g]), .wait_id (c_wait_id[g]),
      .time_stamp (c_time[g]),
      .overlap (c_overlap[g]), .row_hit (c_row_hit[g])
    );
  end

  // Find: newest held overlapping entry. Count: held row hits.
  logic                 f_found;
  logic [ID_BITS-1:0]   f_id;
  logic [CNT_BITS-1:0]  f_runs;
  always_comb begin
    f_found = 1'b0;
    f_id    = '0;
    f_runs  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (CNT_BITS'(k) < held) begin
        if (c_overlap[k]) begin
          f_found = 1'b1;
          f_id    = c_id[k];
        end
        if (c_row_hit[k]) f_runs = f_runs + CNT_BITS'(1);
      end
    end
  end

  // Phase 2: front status after the update, read from the chain.
  logic [1:0]          s_err;
  logic                s_found;
  logic [ID_BITS-1:0]  s_mid;
  logic [CNT_BITS-1:0] s_runs;

  assign in_stall = busy || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; phase2 <= 1'b0; out_valid <= 1'b0; held <= '0;
    end else begin
      // output register loads when free or being transferred, otherwise drains on a transfer
      if (phase2 && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)        out_valid <= 1'b0;
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
        r_kind <= kind; r_id <= txn_id; r_addr <= start_address;
        r_len <= byte_count; r_row <= dram_row; r_write <= is_write;
        r_dvalid <= dep_valid; r_dep <= dep_id; r_time <= arrival_time;
        r_cw <= count_writes;
      end else if (busy && !phase2) begin
        phase2  <= 1'b1;
        s_err   <= err;
        s_found <= (r_kind == dtrq_pkg::KIND_FIND) && f_found;
        s_mid   <= (r_kind == dtrq_pkg::KIND_FIND) ? f_id : '0;
        s_runs  <= (r_kind == dtrq_pkg::KIND_COUNT) ? f_runs : '0;
        if (cmd.load)  held <= held + CNT_BITS'(1);
        if (cmd.shift) held <= held - CNT_BITS'(1);
      end else if (phase2 && !(out_valid && out_stall)) begin
        phase2 <= 1'b0; busy <= 1'b0;
        error_code <= s_err; match_found <= s_found; match_id <= s_mid;
        run_count <= s_runs; occupancy <= held;
        front_ready     <= !empty && !c_waiting[0];
        front_id        <= empty ? '0 : c_id[0];
        front_dep_valid <= !empty && c_waiting[0];
        front_dep_id    <= (!empty && c_waiting[0]) ? c_wait_id[0] : '0;
        front_time      <= empty ? '0 : c_time[0];
      end
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_BITS'(DEPTH)) else $error("occupancy over depth");
  a_phase: assert property (@(posedge clk) disable iff (rst)
    phase2 |-> busy) else $error("phase without busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("accept while busy");
  a_ready_cons: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(front_ready && front_dep_valid)) else $error("front status");

endmodule
